/* hdl/qes_pkg.sv */
// shared types and constants for the queue engine with search and remove
// no dependencies
`default_nettype none
package qes_pkg;

    localparam int QES_DEPTH = 16;

    localparam logic [2:0] REQ_ENQUEUE = 3'd0;
    localparam logic [2:0] REQ_DEQUEUE = 3'd1;
    localparam logic [2:0] REQ_PUSH    = 3'd2;
    localparam logic [2:0] REQ_SEARCH  = 3'd3;
    localparam logic [2:0] REQ_REMOVE  = 3'd4;
    localparam logic [2:0] REQ_ROTATE  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEQ,
        S_SCAN,
        S_CHK,
        S_ROT_RD,
        S_ROT_WR
    } t_state;

endpackage
`default_nettype wire

/* hdl/qes_ram.sv */
// entry store: one write port, one read port with registered read data
// depends on qes_pkg for the default depth
`default_nettype none
module qes_ram #(
    parameter int DEPTH = qes_pkg::QES_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [31:0]   o_rdata
);
    import qes_pkg::*;

    logic [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* hdl/queue_engine_with_search_remove.sv */
// top level: ring queue control, head and count registers, result register
// depends on qes_pkg and qes_ram
//
//  channel | handshake        | fields
//  request | start / busy     | i_req_type, i_item_value, i_rotate_count
//  result  | o_valid (strobe) | o_result_value, o_found, o_status, o_occupancy
//
// enqueue and push front finish straight from idle; dequeue, search, remove and
// rotate step through read and write accesses of the single-port-pair entry
// store. the result strobe is registered and shows in the cycle after the last
// step, and the next item may be started in that same cycle.
// reset clears head, count and control; the entry store holds no reset.
// the receiver cannot stall, so each result shows for exactly one cycle.
`default_nettype none
module queue_engine_with_search_remove #(
    parameter int DEPTH = qes_pkg::QES_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [2:0]  i_req_type,
    input  wire logic signed [31:0] i_item_value,
    input  wire logic        [7:0]  i_rotate_count,
    output logic                    o_valid,
    output logic signed      [31:0] o_result_value,
    output logic                    o_found,
    output logic             [1:0]  o_status,
    output logic             [4:0]  o_occupancy
);
    import qes_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state         r_state, n_state;
    logic [2:0]     r_req, n_req;
    logic [31:0]    r_val, n_val;
    logic [7:0]     r_rot, n_rot;
    logic [AW-1:0]  r_head, n_head;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_i, n_i;
    logic [CW-1:0]  r_k, n_k;
    logic           r_found, n_found;
    logic           r_valid, n_valid;
    logic [31:0]    r_res, n_res;
    logic           r_fnd, n_fnd;
    logic [1:0]     r_status, n_status;
    logic [4:0]     r_occ, n_occ;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    logic [31:0]    wdata, rdata;

    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] head,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(off);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [4:0] occ5(input logic [CW-1:0] c);
        logic [CW+4:0] t;
        t = (CW+5)'(c);
        return t[4:0];
    endfunction

    qes_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_req_type)
                        REQ_DEQUEUE: begin
                            if (r_count != '0) n_state = S_DEQ;
                        end
                        REQ_SEARCH, REQ_REMOVE: n_state = S_SCAN;
                        REQ_ROTATE: begin
                            if (r_count != '0 && i_rotate_count != 8'd0) n_state = S_ROT_RD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_DEQ: n_state = S_IDLE;
            S_SCAN: begin
                n_state = (r_i == r_count) ? S_IDLE : S_CHK;
            end
            S_CHK: begin
                if (r_req == REQ_SEARCH && rdata == r_val) n_state = S_IDLE;
                else n_state = S_SCAN;
            end
            S_ROT_RD: n_state = S_ROT_WR;
            S_ROT_WR: begin
                n_state = (r_rot == 8'd1) ? S_IDLE : S_ROT_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_req    = r_req;
        n_val    = r_val;
        n_rot    = r_rot;
        n_head   = r_head;
        n_count  = r_count;
        n_i      = r_i;
        n_k      = r_k;
        n_found  = r_found;
        n_valid  = 1'b0;
        n_res    = r_res;
        n_fnd    = r_fnd;
        n_status = r_status;
        n_occ    = r_occ;
        we       = 1'b0;
        waddr    = r_head;
        wdata    = r_val;
        raddr    = r_head;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req    = i_req_type;
                    n_val    = i_item_value;
                    n_rot    = i_rotate_count;
                    n_i      = '0;
                    n_k      = '0;
                    n_found  = 1'b0;
                    n_res    = '0;
                    n_fnd    = 1'b0;
                    n_status = ST_OK;
                    n_occ    = occ5(r_count);
                    case (i_req_type)
                        REQ_ENQUEUE: begin
                            n_valid = 1'b1;
                            if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                waddr   = ring_pos(r_head, r_count);
                                wdata   = i_item_value;
                                n_count = r_count + 1'b1;
                                n_occ   = occ5(r_count + 1'b1);
                            end
                        end
                        REQ_DEQUEUE: begin
                            if (r_count == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end
                        end
                        REQ_PUSH: begin
                            n_valid = 1'b1;
                            if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_head  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
                                we      = 1'b1;
                                waddr   = n_head;
                                wdata   = i_item_value;
                                n_count = r_count + 1'b1;
                                n_occ   = occ5(r_count + 1'b1);
                            end
                        end
                        REQ_SEARCH, REQ_REMOVE: begin
                            n_valid = 1'b0;
                        end
                        REQ_ROTATE: begin
                            if (r_count == '0 || i_rotate_count == 8'd0) n_valid = 1'b1;
                        end
                        default: n_valid = 1'b1;
                    endcase
                end
            end
            S_DEQ: begin
                n_valid = 1'b1;
                n_res   = rdata;
                n_head  = ring_pos(r_head, CW'(1));
                n_count = r_count - 1'b1;
                n_occ   = occ5(r_count - 1'b1);
            end
            S_SCAN: begin
                raddr = ring_pos(r_head, r_i);
                if (r_i == r_count) begin
                    n_valid = 1'b1;
                    n_fnd   = r_found;
                    if (r_req == REQ_REMOVE) begin
                        n_count = r_k;
                        n_occ   = occ5(r_k);
                    end
                end
            end
            S_CHK: begin
                n_i = r_i + 1'b1;
                if (rdata == r_val) begin
                    n_found = 1'b1;
                    if (r_req == REQ_SEARCH) begin
                        n_valid = 1'b1;
                        n_fnd   = 1'b1;
                    end
                end else if (r_req == REQ_REMOVE) begin
                    // compact survivors toward the front, write never passes read
                    we    = 1'b1;
                    waddr = ring_pos(r_head, r_k);
                    wdata = rdata;
                    n_k   = r_k + 1'b1;
                end
            end
            S_ROT_RD: begin
                raddr = r_head;
            end
            S_ROT_WR: begin
                // front entry goes just past the current back
                we     = 1'b1;
                waddr  = ring_pos(r_head, r_count);
                wdata  = rdata;
                n_head = ring_pos(r_head, CW'(1));
                n_rot  = r_rot - 1'b1;
                if (r_rot == 8'd1) n_valid = 1'b1;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_req    <= n_req;
        r_val    <= n_val;
        r_rot    <= n_rot;
        r_i      <= n_i;
        r_k      <= n_k;
        r_found  <= n_found;
        r_res    <= n_res;
        r_fnd    <= n_fnd;
        r_status <= n_status;
        r_occ    <= n_occ;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_result_value = r_res;
    assign o_found        = r_fnd;
    assign o_status       = r_status;
    assign o_occupancy    = r_occ;

endmodule
`default_nettype wire

/* test/tb_top.sv */
// testbench for the queue engine with search and remove: directed and random items,
// checked against an in-bench ring queue predictor; depends on qes_pkg and the dut
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import qes_pkg::*;

    typedef struct packed {
        logic signed [31:0] value;
        logic               found;
        logic [1:0]         status;
        logic [4:0]         occupancy;
    } t_qresult;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_req_type;
    logic signed [31:0] i_item_value;
    logic [7:0]         i_rotate_count;
    logic               o_valid;
    logic signed [31:0] o_result_value;
    logic               o_found;
    logic [1:0]         o_status;
    logic [4:0]         o_occupancy;

    queue_engine_with_search_remove dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_item_value(i_item_value),
        .i_rotate_count(i_rotate_count), .o_valid(o_valid),
        .o_result_value(o_result_value), .o_found(o_found),
        .o_status(o_status), .o_occupancy(o_occupancy)
    );

    // predictor state
    logic [31:0] ring [QES_DEPTH];
    logic [3:0]  front;
    int          count;
    t_qresult    pending_results[$];
    int          errors;
    int          idle_pct;
    logic [31:0] recent[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("queue_engine_with_search_remove: mismatch");
        $finish;
    end

    function automatic t_qresult predict_queue(input logic [2:0] req,
                                               input logic [31:0] val,
                                               input logic [7:0] rot);
        t_qresult r;
        int k;
        logic [31:0] v;
        r = '0;
        case (req)
            REQ_ENQUEUE: begin
                if (count >= QES_DEPTH) r.status = ST_FULL;
                else begin
                    ring[(front + count) % QES_DEPTH] = val;
                    count++;
                end
            end
            REQ_DEQUEUE: begin
                if (count == 0) r.status = ST_EMPTY;
                else begin
                    r.value = ring[front];
                    front = front + 4'd1;
                    count--;
                end
            end
            REQ_PUSH: begin
                if (count >= QES_DEPTH) r.status = ST_FULL;
                else begin
                    front = front - 4'd1;
                    ring[front] = val;
                    count++;
                end
            end
            REQ_SEARCH: begin
                for (int i = 0; i < count; i++)
                    if (ring[(front + i) % QES_DEPTH] == val) r.found = 1'b1;
            end
            REQ_REMOVE: begin
                k = 0;
                for (int i = 0; i < count; i++) begin
                    v = ring[(front + i) % QES_DEPTH];
                    if (v == val) r.found = 1'b1;
                    else begin
                        ring[(front + k) % QES_DEPTH] = v;
                        k++;
                    end
                end
                count = k;
            end
            REQ_ROTATE: begin
                if (count != 0)
                    for (int i = 0; i < rot; i++) begin
                        v = ring[front];
                        front = front + 4'd1;
                        ring[(front + count - 1) % QES_DEPTH] = v;
                    end
            end
            default: ;
        endcase
        r.occupancy = count[4:0];
        return r;
    endfunction

    // optionally idle, then hold start until accepted
    task automatic send_request(input logic [2:0] req, input logic [31:0] val,
                                input logic [7:0] rot);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_req_type     <= req;
        i_item_value   <= val;
        i_rotate_count <= rot;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(predict_queue(req, val, rot));
        if (count > 0 && val != 0) recent.push_back(val);
        if (recent.size() > 8) void'(recent.pop_front());
    endtask

    always @(posedge i_clk) begin
        t_qresult exp_r;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result with no item pending");
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_result_value !== exp_r.value) begin
                    $error("result_value exp %0d got %0d", exp_r.value, o_result_value);
                    errors++;
                end
                if (o_found !== exp_r.found) begin
                    $error("found exp %0d got %0d", exp_r.found, o_found);
                    errors++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, o_status);
                    errors++;
                end
                if (o_occupancy !== exp_r.occupancy) begin
                    $error("occupancy exp %0d got %0d", exp_r.occupancy, o_occupancy);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5) return 32'($urandom_range(7));
        if (sel < 7 && recent.size() > 0) return recent[$urandom_range(recent.size() - 1)];
        if (sel == 7) return {$urandom_range(1) ? 1'b1 : 1'b0, 31'($urandom_range(1))};
        return $urandom;
    endfunction

    task automatic test_directed();
        send_request(REQ_DEQUEUE, 32'd0, 8'd0);          // dequeue when empty
        send_request(REQ_ROTATE, 32'd0, 8'd5);           // rotate when empty
        send_request(REQ_SEARCH, 32'd0, 8'd0);
        send_request(REQ_REMOVE, 32'd0, 8'd0);
        send_request(REQ_ENQUEUE, 32'h8000_0000, 8'd0);
        send_request(REQ_PUSH, 32'h7fff_ffff, 8'd0);
        send_request(REQ_ENQUEUE, 32'hffff_ffff, 8'd0);
        send_request(REQ_SEARCH, 32'h8000_0000, 8'hff);
        send_request(REQ_ROTATE, 32'hffff_ffff, 8'd0);   // count zero
        send_request(REQ_ROTATE, 32'd0, 8'd255);
        send_request(3'd6, 32'hffff_ffff, 8'hff);        // unused codes
        send_request(3'd7, 32'd0, 8'd0);
        for (int i = 0; i < 14; i++) send_request(REQ_ENQUEUE, 32'(i & 1), 8'd0);
        send_request(REQ_ENQUEUE, 32'd9, 8'd0);          // full
        send_request(REQ_PUSH, 32'd9, 8'd0);             // full
        send_request(REQ_REMOVE, 32'd1, 8'd0);
        send_request(REQ_DEQUEUE, 32'd0, 8'd0);
    endtask

    task automatic test_random(input int n);
        logic [2:0] req;
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (sel < 25) req = REQ_ENQUEUE;
            else if (sel < 42) req = REQ_DEQUEUE;
            else if (sel < 55) req = REQ_PUSH;
            else if (sel < 72) req = REQ_SEARCH;
            else if (sel < 84) req = REQ_REMOVE;
            else if (sel < 97) req = REQ_ROTATE;
            else req = 3'($urandom_range(7, 6));
            send_request(req, pick_value(),
                         $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(20)));
        end
    endtask

    initial begin
        errors = 0;
        front = '0;
        count = 0;
        idle_pct = 6;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req_type = '0;
        i_item_value = '0;
        i_rotate_count = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400);
        idle_pct = 87;
        test_random(400);
        idle_pct = 0;
        test_random(400);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("queue_engine_with_search_remove: match");
        else
            $display("queue_engine_with_search_remove: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
